>>> rtl/core/ealu_pkg.sv
// ----------------------------------------------------------------------------
// ealu_pkg
// Shared types and constants of the 8-bit ALU with Z/N/H/C flags.
// ----------------------------------------------------------------------------
package ealu_pkg;

  localparam int OP_W      = 5;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int FLAG_W    = 4;
  localparam int BIT_IDX_W = 3;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [BYTE_W-1:0] DAA_ADJ_HI   = 8'h60;
  localparam logic [BYTE_W-1:0] DAA_ADJ_LO   = 8'h06;
  localparam logic [BYTE_W-1:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0]        DAA_LO_LIMIT = 4'h9;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_AND    = 5'd4,
    OP_OR     = 5'd5,
    OP_XOR    = 5'd6,
    OP_CP     = 5'd7,
    OP_INC    = 5'd8,
    OP_DEC    = 5'd9,
    OP_DAA    = 5'd10,
    OP_CPL    = 5'd11,
    OP_CCF    = 5'd12,
    OP_SCF    = 5'd13,
    OP_RLC    = 5'd14,
    OP_RL     = 5'd15,
    OP_RRC    = 5'd16,
    OP_RR     = 5'd17,
    OP_SLA    = 5'd18,
    OP_SRA    = 5'd19,
    OP_SRL    = 5'd20,
    OP_SWAP   = 5'd21,
    OP_BIT    = 5'd22,
    OP_SET    = 5'd23,
    OP_RES    = 5'd24,
    OP_SP_ADD = 5'd25
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [BYTE_W-1:0]    operand_a;
    logic [BYTE_W-1:0]    operand_b;
    logic [BIT_IDX_W-1:0] bit_index;
    logic [FLAG_W-1:0]    flags_in;
    logic [WORD_W-1:0]    stack_pointer;
  } ealu_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] result_byte;
    logic [WORD_W-1:0] result_word;
    logic [FLAG_W-1:0] flags_out;
  } ealu_rsp_t;

endpackage

>>> rtl/core/ealu_req_if.sv
// ----------------------------------------------------------------------------
// ealu_req_if
// Operation channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface ealu_req_if import ealu_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [BYTE_W-1:0]    operand_a;
  logic [BYTE_W-1:0]    operand_b;
  logic [BIT_IDX_W-1:0] bit_index;
  logic [FLAG_W-1:0]    flags_in;
  logic [WORD_W-1:0]    stack_pointer;

  modport source (
    output valid, op, operand_a, operand_b, bit_index, flags_in, stack_pointer,
    input  ready
  );

  modport sink (
    input  valid, op, operand_a, operand_b, bit_index, flags_in, stack_pointer,
    output ready
  );

endinterface

>>> rtl/core/ealu_rsp_if.sv
// ----------------------------------------------------------------------------
// ealu_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface ealu_rsp_if import ealu_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] result_byte;
  logic [WORD_W-1:0] result_word;
  logic [FLAG_W-1:0] flags_out;

  modport source (
    output valid, result_byte, result_word, flags_out,
    input  ready
  );

  modport sink (
    input  valid, result_byte, result_word, flags_out,
    output ready
  );

endinterface

>>> rtl/core/ealu_core.sv
// ----------------------------------------------------------------------------
// ealu_core
// Single-pass ALU datapath: byte result, stack pointer word and new flags.
// ----------------------------------------------------------------------------
module ealu_core import ealu_pkg::*; (
  input  ealu_req_t req_i,
  output ealu_rsp_t rsp_o
);

  logic [BYTE_W-1:0]   a;
  logic [BYTE_W-1:0]   b;
  logic [FLAG_W-1:0]   f;
  logic                cin;
  logic                add_t;
  logic                sub_t;
  logic [BYTE_W:0]     add9;
  logic [4:0]          add_lo;
  logic [BYTE_W:0]     sub9;
  logic [4:0]          sub_lo;
  logic [BYTE_W-1:0]   inc_byte;
  logic [BYTE_W-1:0]   dec_byte;
  logic [BYTE_W-1:0]   daa_byte;
  logic                daa_c;
  logic [BYTE_W-1:0]   bit_mask;
  logic [WORD_W-1:0]   sp_off;
  logic [WORD_W-1:0]   sp_sum;
  logic [WORD_W-1:0]   sp_x;
  logic [BYTE_W-1:0]   res_byte;
  logic [WORD_W-1:0]   res_word;
  logic [FLAG_W-1:0]   nf;

  assign a     = req_i.operand_a;
  assign b     = req_i.operand_b;
  assign f     = req_i.flags_in;
  assign cin   = f[FLAG_C];
  assign add_t = (req_i.op == OP_ADC) & cin;
  assign sub_t = (req_i.op == OP_SBC) & cin;

  assign add9   = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, add_t};
  assign add_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, add_t};
  assign sub9   = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, sub_t};
  assign sub_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, sub_t};

  assign inc_byte = a + 8'd1;
  assign dec_byte = a - 8'd1;
  assign bit_mask = 8'd1 << req_i.bit_index;

  assign sp_off = {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
  assign sp_sum = req_i.stack_pointer + sp_off;
  assign sp_x   = req_i.stack_pointer ^ sp_off ^ sp_sum;

  always_comb begin
    daa_byte = a;
    daa_c    = cin;
    if (f[FLAG_N]) begin
      if (f[FLAG_C]) daa_byte = daa_byte - DAA_ADJ_HI;
      if (f[FLAG_H]) daa_byte = daa_byte - DAA_ADJ_LO;
    end else begin
      if (f[FLAG_C] || (a > DAA_HI_LIMIT)) begin
        daa_byte = daa_byte + DAA_ADJ_HI;
        daa_c    = 1'b1;
      end
      if (f[FLAG_H] || (a[3:0] > DAA_LO_LIMIT)) daa_byte = daa_byte + DAA_ADJ_LO;
    end
  end

  always_comb begin
    res_byte = a;
    res_word = '0;
    nf       = f;
    unique case (req_i.op)
      OP_ADD, OP_ADC: begin
        res_byte     = add9[BYTE_W-1:0];
        nf           = '0;
        nf[FLAG_Z]   = ~|add9[BYTE_W-1:0];
        nf[FLAG_H]   = add_lo[4];
        nf[FLAG_C]   = add9[BYTE_W];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        if (req_i.op != OP_CP) res_byte = sub9[BYTE_W-1:0];
        nf           = '0;
        nf[FLAG_Z]   = ~|sub9[BYTE_W-1:0];
        nf[FLAG_N]   = 1'b1;
        nf[FLAG_H]   = sub_lo[4];
        nf[FLAG_C]   = sub9[BYTE_W];
      end
      OP_AND: begin
        res_byte     = a & b;
        nf           = '0;
        nf[FLAG_Z]   = ~|(a & b);
        nf[FLAG_H]   = 1'b1;
      end
      OP_OR: begin
        res_byte     = a | b;
        nf           = '0;
        nf[FLAG_Z]   = ~|(a | b);
      end
      OP_XOR: begin
        res_byte     = a ^ b;
        nf           = '0;
        nf[FLAG_Z]   = ~|(a ^ b);
      end
      OP_INC: begin
        res_byte     = inc_byte;
        nf[FLAG_Z]   = ~|inc_byte;
        nf[FLAG_N]   = 1'b0;
        nf[FLAG_H]   = &a[3:0];
      end
      OP_DEC: begin
        res_byte     = dec_byte;
        nf[FLAG_Z]   = ~|dec_byte;
        nf[FLAG_N]   = 1'b1;
        nf[FLAG_H]   = ~|a[3:0];
      end
      OP_DAA: begin
        res_byte     = daa_byte;
        nf[FLAG_Z]   = ~|daa_byte;
        nf[FLAG_H]   = 1'b0;
        nf[FLAG_C]   = daa_c;
      end
      OP_CPL: begin
        res_byte     = ~a;
        nf[FLAG_N]   = 1'b1;
        nf[FLAG_H]   = 1'b1;
      end
      OP_CCF: begin
        nf[FLAG_N]   = 1'b0;
        nf[FLAG_H]   = 1'b0;
        nf[FLAG_C]   = ~cin;
      end
      OP_SCF: begin
        nf[FLAG_N]   = 1'b0;
        nf[FLAG_H]   = 1'b0;
        nf[FLAG_C]   = 1'b1;
      end
      OP_RLC: begin
        res_byte     = {a[6:0], a[7]};
        nf           = '0;
        nf[FLAG_Z]   = ~|a;
        nf[FLAG_C]   = a[7];
      end
      OP_RL: begin
        res_byte     = {a[6:0], cin};
        nf           = '0;
        nf[FLAG_Z]   = ~|{a[6:0], cin};
        nf[FLAG_C]   = a[7];
      end
      OP_RRC: begin
        res_byte     = {a[0], a[7:1]};
        nf           = '0;
        nf[FLAG_Z]   = ~|a;
        nf[FLAG_C]   = a[0];
      end
      OP_RR: begin
        res_byte     = {cin, a[7:1]};
        nf           = '0;
        nf[FLAG_Z]   = ~|{cin, a[7:1]};
        nf[FLAG_C]   = a[0];
      end
      OP_SLA: begin
        res_byte     = {a[6:0], 1'b0};
        nf           = '0;
        nf[FLAG_Z]   = ~|a[6:0];
        nf[FLAG_C]   = a[7];
      end
      OP_SRA: begin
        res_byte     = {a[7], a[7:1]};
        nf           = '0;
        nf[FLAG_Z]   = ~|a[7:1];
        nf[FLAG_C]   = a[0];
      end
      OP_SRL: begin
        res_byte     = {1'b0, a[7:1]};
        nf           = '0;
        nf[FLAG_Z]   = ~|a[7:1];
        nf[FLAG_C]   = a[0];
      end
      OP_SWAP: begin
        res_byte     = {a[3:0], a[7:4]};
        nf           = '0;
        nf[FLAG_Z]   = ~|a;
      end
      OP_BIT: begin
        nf[FLAG_Z]   = ~|(a & bit_mask);
        nf[FLAG_N]   = 1'b0;
        nf[FLAG_H]   = 1'b1;
      end
      OP_SET: begin
        res_byte     = a | bit_mask;
      end
      OP_RES: begin
        res_byte     = a & ~bit_mask;
      end
      OP_SP_ADD: begin
        res_byte     = '0;
        res_word     = sp_sum;
        nf           = '0;
        nf[FLAG_H]   = sp_x[4];
        nf[FLAG_C]   = sp_x[8];
      end
      default: begin
        res_byte     = a;
      end
    endcase
  end

  assign rsp_o.result_byte = res_byte;
  assign rsp_o.result_word = res_word;
  assign rsp_o.flags_out   = nf;

endmodule

>>> rtl/core/eight_bit_cpu_alu_with_flags_top.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags_top
// 8-bit ALU with Z/N/H/C flags, 16-bit stack pointer offset add.
// ----------------------------------------------------------------------------
// The block takes one operation per clock cycle and returns one result for
// each operation, in order. A transferred operation is held in the operand
// register, then its result goes through the single-pass datapath into the
// result register. Both registers hold under backpressure, so with rsp_o.ready
// held high the block sustains one operation every cycle.
module eight_bit_cpu_alu_with_flags_top import ealu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ealu_req_if.sink   req_i,
  ealu_rsp_if.source rsp_o
);

  ealu_req_t req_q;
  logic      req_valid_q;
  ealu_rsp_t core_rsp;
  ealu_rsp_t rsp_q;
  logic      rsp_valid_q;
  logic      rsp_load;
  logic      req_load;

  assign rsp_load = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || rsp_load;
  assign req_load = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_q.op            <= req_i.op;
      req_q.operand_a     <= req_i.operand_a;
      req_q.operand_b     <= req_i.operand_b;
      req_q.bit_index     <= req_i.bit_index;
      req_q.flags_in      <= req_i.flags_in;
      req_q.stack_pointer <= req_i.stack_pointer;
    end
  end

  ealu_core u_core (
    .req_i (req_q),
    .rsp_o (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (!rsp_valid_q || rsp_o.ready) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q <= core_rsp;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.result_byte = rsp_q.result_byte;
  assign rsp_o.result_word = rsp_q.result_word;
  assign rsp_o.flags_out   = rsp_q.flags_out;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_valid_q |-> req_i.ready)
    else $error("operand register empty but not ready");

  a_ready_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.ready && req_valid_q) |-> rsp_load)
    else $error("ready with full operand register that does not advance");

  a_result_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |=> (rsp_valid_q && (rsp_q == $past(core_rsp))))
    else $error("result register lost a computed result");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !rsp_load) |=> req_valid_q)
    else $error("stalled operation dropped");

endmodule

>>> sim/eight_bit_cpu_alu_with_flags_top_test.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags_top_test
// Drives a table of directed operations and then random ones through the
// operation channel, gets byte, word and flags for each transfer from the
// table or a prediction, and compares every result in order. Sender gaps
// and receiver stalls vary in phases, and one long receiver hold-off backs up the pipeline.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_with_flags_top_test import ealu_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_OPS   = 1700;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 150;
  localparam int MAX_REPORTS  = 100;

  localparam logic [OP_W-1:0] OP_NOP_FIRST = OP_W'(OP_SP_ADD + 1);
  localparam logic [OP_W-1:0] OP_NOP_LAST  = '1;

  typedef struct packed {
    ealu_req_t q;
    logic      typed;
    ealu_rsp_t rsp;
  } alu_row_t;

  localparam int DIR_N = 29;
  localparam alu_row_t DIR_ROWS [DIR_N] = '{
    '{'{OP_ADD,    8'hFF, 8'h01, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'h00, 16'h0000, 4'b1011}},
    '{'{OP_ADC,    8'h0F, 8'h00, 3'd0, 4'b0001, 16'h0000}, 1'b1, '{8'h10, 16'h0000, 4'b0010}},
    '{'{OP_SUB,    8'h00, 8'h01, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'hFF, 16'h0000, 4'b0111}},
    '{'{OP_SBC,    8'hFF, 8'hFF, 3'd0, 4'b0001, 16'h0000}, 1'b1, '{8'hFF, 16'h0000, 4'b0111}},
    '{'{OP_AND,    8'hFF, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'h00, 16'h0000, 4'b1010}},
    '{'{OP_OR,     8'hA5, 8'h5A, 3'd0, 4'b1111, 16'h0000}, 1'b1, '{8'hFF, 16'h0000, 4'b0000}},
    '{'{OP_XOR,    8'hFF, 8'hFF, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'h00, 16'h0000, 4'b1000}},
    '{'{OP_CP,     8'h42, 8'h42, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'h42, 16'h0000, 4'b1100}},
    '{'{OP_INC,    8'hFF, 8'h00, 3'd0, 4'b0001, 16'h0000}, 1'b1, '{8'h00, 16'h0000, 4'b1011}},
    '{'{OP_DEC,    8'h00, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'hFF, 16'h0000, 4'b0110}},
    '{'{OP_DAA,    8'h9A, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'h00, 16'h0000, 4'b1001}},
    '{'{OP_DAA,    8'h00, 8'h00, 3'd0, 4'b0111, 16'h0000}, 1'b0, '0},
    '{'{OP_CPL,    8'h00, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'hFF, 16'h0000, 4'b0110}},
    '{'{OP_CCF,    8'h3C, 8'h00, 3'd0, 4'b1111, 16'h0000}, 1'b1, '{8'h3C, 16'h0000, 4'b1000}},
    '{'{OP_SCF,    8'h3C, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'h3C, 16'h0000, 4'b0001}},
    '{'{OP_RLC,    8'h80, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b0, '0},
    '{'{OP_RL,     8'h80, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'h00, 16'h0000, 4'b1001}},
    '{'{OP_RRC,    8'h01, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b0, '0},
    '{'{OP_RR,     8'h01, 8'h00, 3'd0, 4'b0001, 16'h0000}, 1'b0, '0},
    '{'{OP_SLA,    8'hFF, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b0, '0},
    '{'{OP_SRA,    8'h80, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b0, '0},
    '{'{OP_SRL,    8'h01, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b1, '{8'h00, 16'h0000, 4'b1001}},
    '{'{OP_SWAP,   8'hF0, 8'h00, 3'd0, 4'b0000, 16'h0000}, 1'b0, '0},
    '{'{OP_BIT,    8'h7F, 8'h00, 3'd7, 4'b0001, 16'h0000}, 1'b1, '{8'h7F, 16'h0000, 4'b1011}},
    '{'{OP_SET,    8'h00, 8'h00, 3'd7, 4'b1010, 16'h0000}, 1'b0, '0},
    '{'{OP_RES,    8'hFF, 8'h00, 3'd0, 4'b0101, 16'h0000}, 1'b0, '0},
    '{'{OP_SP_ADD, 8'h00, 8'h01, 3'd0, 4'b1111, 16'hFFFF}, 1'b1, '{8'h00, 16'h0000, 4'b0011}},
    '{'{OP_SP_ADD, 8'h00, 8'h80, 3'd0, 4'b0000, 16'h0000}, 1'b0, '0},
    '{'{OP_NOP_LAST, 8'h5A, 8'hC3, 3'd5, 4'b1010, 16'h1234}, 1'b1, '{8'h5A, 16'h0000, 4'b1010}}
  };

  logic clk_i;
  logic rst_ni;

  ealu_req_if req_if ();
  ealu_rsp_if rsp_if ();

  eight_bit_cpu_alu_with_flags_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic        typed_now;
  ealu_rsp_t   typed_rsp_now;
  ealu_rsp_t   alu_results_q [$];
  int unsigned op_count    = 0;
  int unsigned cycle_count = 0;
  int unsigned err_count   = 0;
  bit          hold_done   = 1'b0;

  function automatic ealu_rsp_t predict_alu(input ealu_req_t q);
    logic [7:0]  a, b, r;
    logic [3:0]  f, nf;
    logic        cin, cb;
    logic [8:0]  full;
    logic [4:0]  nib;
    logic [15:0] off, w, carries;
    ealu_rsp_t   rsp;
    a   = q.operand_a;
    b   = q.operand_b;
    f   = q.flags_in;
    cin = f[FLAG_C];
    r   = a;
    w   = '0;
    nf  = f;
    case (q.op)
      OP_ADD, OP_ADC: begin
        cb   = (q.op == OP_ADC) && cin;
        full = {1'b0, a} + {1'b0, b} + {8'd0, cb};
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cb};
        r    = full[7:0];
        nf   = {r == 8'h00, 1'b0, nib[4], full[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cb   = (q.op == OP_SBC) && cin;
        full = {1'b0, a} - {1'b0, b} - {8'd0, cb};
        nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cb};
        nf   = {full[7:0] == 8'h00, 1'b1, nib[4], full[8]};
        r    = (q.op == OP_CP) ? a : full[7:0];
      end
      OP_AND: begin
        r  = a & b;
        nf = {r == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_OR: begin
        r  = a | b;
        nf = {r == 8'h00, 3'b000};
      end
      OP_XOR: begin
        r  = a ^ b;
        nf = {r == 8'h00, 3'b000};
      end
      OP_INC: begin
        r  = a + 8'd1;
        nf = {r == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
      end
      OP_DEC: begin
        r  = a - 8'd1;
        nf = {r == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
      end
      OP_DAA: begin
        cb = cin;
        if (f[FLAG_N]) begin
          if (f[FLAG_C]) r = r - DAA_ADJ_HI;
          if (f[FLAG_H]) r = r - DAA_ADJ_LO;
        end else begin
          if (f[FLAG_C] || a > DAA_HI_LIMIT) begin
            r  = r + DAA_ADJ_HI;
            cb = 1'b1;
          end
          if (f[FLAG_H] || a[3:0] > DAA_LO_LIMIT) r = r + DAA_ADJ_LO;
        end
        nf = {r == 8'h00, f[FLAG_N], 1'b0, cb};
      end
      OP_CPL: begin
        r  = ~a;
        nf = {f[FLAG_Z], 1'b1, 1'b1, cin};
      end
      OP_CCF:  nf = {f[FLAG_Z], 2'b00, ~cin};
      OP_SCF:  nf = {f[FLAG_Z], 2'b00, 1'b1};
      OP_RLC: begin
        r  = {a[6:0], a[7]};
        nf = {r == 8'h00, 2'b00, a[7]};
      end
      OP_RL: begin
        r  = {a[6:0], cin};
        nf = {r == 8'h00, 2'b00, a[7]};
      end
      OP_RRC: begin
        r  = {a[0], a[7:1]};
        nf = {r == 8'h00, 2'b00, a[0]};
      end
      OP_RR: begin
        r  = {cin, a[7:1]};
        nf = {r == 8'h00, 2'b00, a[0]};
      end
      OP_SLA: begin
        r  = {a[6:0], 1'b0};
        nf = {r == 8'h00, 2'b00, a[7]};
      end
      OP_SRA: begin
        r  = {a[7], a[7:1]};
        nf = {r == 8'h00, 2'b00, a[0]};
      end
      OP_SRL: begin
        r  = {1'b0, a[7:1]};
        nf = {r == 8'h00, 2'b00, a[0]};
      end
      OP_SWAP: begin
        r  = {a[3:0], a[7:4]};
        nf = {r == 8'h00, 3'b000};
      end
      OP_BIT:  nf = {~a[q.bit_index], 1'b0, 1'b1, cin};
      OP_SET:  r = a | (8'd1 << q.bit_index);
      OP_RES:  r = a & ~(8'd1 << q.bit_index);
      OP_SP_ADD: begin
        off     = {{8{b[7]}}, b};
        w       = q.stack_pointer + off;
        carries = q.stack_pointer ^ off ^ w;
        nf      = {2'b00, carries[4], carries[8]};
        r       = '0;
      end
      default: ;
    endcase
    rsp.result_byte = r;
    rsp.result_word = w;
    rsp.flags_out   = nf;
    return rsp;
  endfunction

  function automatic logic [7:0] corner_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      4:       return 8'h0F;
      5:       return 8'hF0;
      6:       return 8'h99;
      default: return 8'h9A;
    endcase
  endfunction

  function automatic ealu_req_t random_op();
    ealu_req_t q;
    if ($urandom_range(19) == 0) q.op = OP_W'($urandom_range(OP_NOP_LAST, OP_NOP_FIRST));
    else                         q.op = OP_W'($urandom_range(OP_SP_ADD));
    q.operand_a     = ($urandom_range(3) == 0) ? corner_byte() : 8'($urandom());
    q.operand_b     = ($urandom_range(3) == 0) ? corner_byte() : 8'($urandom());
    q.bit_index     = 3'($urandom());
    q.flags_in      = 4'($urandom());
    q.stack_pointer = ($urandom_range(4) == 0) ? {corner_byte(), corner_byte()}
                                                : 16'($urandom());
    return q;
  endfunction

  function automatic int sender_idle_pct(input int unsigned n);
    if (n < DIR_N + 400)  return 0;
    if (n < DIR_N + 800)  return 81;
    if (n < DIR_N + 1200) return 0;
    if (n < DIR_N + 1600) return 28;
    return 0;
  endfunction

  function automatic int receiver_stall_pct(input int unsigned n);
    if (n < DIR_N + 800)  return 0;
    if (n < DIR_N + 1200) return 81;
    if (n < DIR_N + 1600) return 28;
    return 0;
  endfunction

  // Call at a rising edge; returns at the edge of the transfer.
  task automatic send_op(input ealu_req_t q, input logic typed, input ealu_rsp_t rsp);
    while ($urandom_range(99) < sender_idle_pct(op_count)) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.op            <= q.op;
    req_if.operand_a     <= q.operand_a;
    req_if.operand_b     <= q.operand_b;
    req_if.bit_index     <= q.bit_index;
    req_if.flags_in      <= q.flags_in;
    req_if.stack_pointer <= q.stack_pointer;
    typed_now            <= typed;
    typed_rsp_now        <= rsp;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: random stalls per phase, one long hold-off to back up the pipe.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && op_count >= HOLD_AT) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct(op_count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, alu_results_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check the result transfer first, then record the operation transfer.
  always @(posedge clk_i) begin
    ealu_req_t seen;
    ealu_rsp_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (alu_results_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: result with none expected: byte %02h word %04h flags %04b",
                     $time, rsp_if.result_byte, rsp_if.result_word, rsp_if.flags_out);
        end else begin
          want = alu_results_q.pop_front();
          if (rsp_if.result_byte !== want.result_byte) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: result_byte expected %02h actual %02h",
                       $time, want.result_byte, rsp_if.result_byte);
          end
          if (rsp_if.result_word !== want.result_word) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: result_word expected %04h actual %04h",
                       $time, want.result_word, rsp_if.result_word);
          end
          if (rsp_if.flags_out !== want.flags_out) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: flags_out expected %04b actual %04b",
                       $time, want.flags_out, rsp_if.flags_out);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        seen = '{req_if.op, req_if.operand_a, req_if.operand_b, req_if.bit_index,
                 req_if.flags_in, req_if.stack_pointer};
        alu_results_q.push_back(typed_now ? typed_rsp_now : predict_alu(seen));
        op_count <= op_count + 1;
      end
    end
  end

  initial begin
    req_if.valid         <= 1'b0;
    req_if.op            <= '0;
    req_if.operand_a     <= '0;
    req_if.operand_b     <= '0;
    req_if.bit_index     <= '0;
    req_if.flags_in      <= '0;
    req_if.stack_pointer <= '0;
    typed_now            <= 1'b0;
    typed_rsp_now        <= '0;
    @(posedge rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < DIR_N; i++) begin
      send_op(DIR_ROWS[i].q, DIR_ROWS[i].typed, DIR_ROWS[i].rsp);
    end
    for (int i = 0; i < RANDOM_OPS; i++) begin
      send_op(random_op(), 1'b0, '0);
    end
    req_if.valid <= 1'b0;
    while (alu_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
